// ===== hw/rtl/sle_pkg.sv =====
package sle_pkg;

  // Number of cells, one stored value each.
  localparam int DEPTH = 16;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FILL_W = $clog2(DEPTH + 1);

  // Field widths of the channels.
  localparam int MODE_W = 3;
  localparam int VALUE_W = 32;
  localparam int STATUS_W = 2;
  localparam int POS_W = 4;
  localparam int COUNT_W = 5;

  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT = 3'd0,
    MODE_SEARCH = 3'd1,
    MODE_DELETE = 3'd2,
    MODE_CLEAR  = 3'd3,
    MODE_COUNT  = 3'd4
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_MISSING = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  // Broadcast to every cell in the cycle an item is taken.
  typedef struct packed {
    logic                      ins;
    logic                      del;
    logic signed [VALUE_W-1:0] value;
  } cell_ctl_t;

endpackage

// ===== hw/rtl/sle_cell.sv =====
module sle_cell (
  input  logic                               clk,
  input  sle_pkg::cell_ctl_t                 ctl,
  input  logic                               valid,
  input  logic                               left_gt,
  input  logic signed [sle_pkg::VALUE_W-1:0] left_entry,
  input  logic signed [sle_pkg::VALUE_W-1:0] right_entry,
  output logic signed [sle_pkg::VALUE_W-1:0] entry,
  output logic                               gt,
  output logic                               lt,
  output logic                               eq
);

  // An empty cell counts as greater than anything, so the greater flags
  // along the row form a thermometer that marks the insert point.
  assign gt = !valid || (entry > ctl.value);
  assign lt = valid && (entry < ctl.value);
  assign eq = valid && (entry == ctl.value);

  always_ff @(posedge clk) begin
    if (ctl.ins && gt) begin
      entry <= left_gt ? left_entry : ctl.value;
    end else if (ctl.del && !lt) begin
      entry <= right_entry;
    end
  end

endmodule

// ===== hw/rtl/sorted_list_engine.sv =====
// Channel  | Valid / ready          | Payload
// ---------+------------------------+--------------------------------------
// input    | in_valid / in_ready    | mode [2:0], value [31:0] signed
// output   | out_valid / out_ready  | status [1:0], found, position [3:0],
//          |                        | count [4:0]
//
// All cells compare against the value at once and shift by one place, so
// one item can be taken per clock while in_ready is high. The result
// appears in the cycle after its transfer, from a registered output stage.
// Input is taken whenever the output stage is empty or is being drained,
// so a stalled consumer holds off new items only while a result waits.
// Reset (rst, synchronous) empties the store and the output stage; the
// stored values themselves are not cleared, since the fill count masks them.
module sorted_list_engine (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [sle_pkg::MODE_W-1:0]          mode,
  input  logic signed [sle_pkg::VALUE_W-1:0]  value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [sle_pkg::STATUS_W-1:0]        status,
  output logic                                found,
  output logic [sle_pkg::POS_W-1:0]           position,
  output logic [sle_pkg::COUNT_W-1:0]         count
);

  localparam int DEPTH = sle_pkg::DEPTH;
  localparam int IDX_W = sle_pkg::IDX_W;
  localparam int FILL_W = sle_pkg::FILL_W;

  // The number of stored values; cells below it hold valid entries.
  logic [FILL_W-1:0] fill;
  logic [FILL_W-1:0] fill_next;

  logic accept;
  logic [DEPTH-1:0] valid_vec;
  logic [DEPTH-1:0] gt_vec;
  logic [DEPTH-1:0] lt_vec;
  logic [DEPTH-1:0] eq_vec;
  logic signed [sle_pkg::VALUE_W-1:0] entries [DEPTH];

  sle_pkg::cell_ctl_t ctl;
  logic hit;
  logic is_full;
  logic is_empty;
  logic [IDX_W-1:0] ins_idx;
  logic [IDX_W-1:0] match_idx;

  sle_pkg::status_t status_next;
  logic found_next;
  logic [IDX_W-1:0] pos_next;

  assign in_ready = !out_valid || out_ready;
  assign accept = in_valid && in_ready;

  assign is_full = (fill == FILL_W'(DEPTH));
  assign is_empty = (fill == '0);
  assign hit = |eq_vec;

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      valid_vec[i] = (FILL_W'(i) < fill);
    end
  end

  // Both flag rows are thermometers, so the insert point is the first
  // greater cell and the first match is the first cell that is not less.
  always_comb begin
    ins_idx = '0;
    match_idx = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (gt_vec[i] && (i == 0 || !gt_vec[(i > 0) ? i - 1 : 0])) begin
        ins_idx = ins_idx | IDX_W'(i);
      end
      if (!lt_vec[i] && (i == 0 || lt_vec[(i > 0) ? i - 1 : 0])) begin
        match_idx = match_idx | IDX_W'(i);
      end
    end
  end

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      logic left_gt;
      logic signed [sle_pkg::VALUE_W-1:0] left_entry;
      logic signed [sle_pkg::VALUE_W-1:0] right_entry;

      if (g == 0) begin : g_first
        assign left_gt = 1'b0;
        assign left_entry = value;
      end else begin : g_inner
        assign left_gt = gt_vec[g-1];
        assign left_entry = entries[g-1];
      end

      if (g == DEPTH - 1) begin : g_last
        assign right_entry = '0;
      end else begin : g_mid
        assign right_entry = entries[g+1];
      end

      sle_cell u_cell (
        .clk         (clk),
        .ctl         (ctl),
        .valid       (valid_vec[g]),
        .left_gt     (left_gt),
        .left_entry  (left_entry),
        .right_entry (right_entry),
        .entry       (entries[g]),
        .gt          (gt_vec[g]),
        .lt          (lt_vec[g]),
        .eq          (eq_vec[g])
      );
    end
  endgenerate

  // Decode the request against the current fill and match flags.
  always_comb begin
    ctl.ins = 1'b0;
    ctl.del = 1'b0;
    ctl.value = value;
    status_next = sle_pkg::ST_OK;
    found_next = 1'b0;
    pos_next = '0;
    fill_next = fill;
    unique case (sle_pkg::mode_t'(mode))
      sle_pkg::MODE_INSERT: begin
        if (is_full) begin
          status_next = sle_pkg::ST_FULL;
        end else begin
          ctl.ins = accept;
          pos_next = ins_idx;
          fill_next = fill + FILL_W'(1);
        end
      end
      sle_pkg::MODE_SEARCH, sle_pkg::MODE_DELETE: begin
        if (is_empty) begin
          status_next = sle_pkg::ST_EMPTY;
        end else if (!hit) begin
          status_next = sle_pkg::ST_MISSING;
        end else begin
          found_next = 1'b1;
          pos_next = match_idx;
          if (sle_pkg::mode_t'(mode) == sle_pkg::MODE_DELETE) begin
            ctl.del = accept;
            fill_next = fill - FILL_W'(1);
          end
        end
      end
      sle_pkg::MODE_CLEAR: begin
        if (is_empty) begin
          status_next = sle_pkg::ST_EMPTY;
        end
        fill_next = '0;
      end
      sle_pkg::MODE_COUNT: begin
        if (is_empty) begin
          status_next = sle_pkg::ST_EMPTY;
        end
      end
      default: begin
        // Unused modes leave the store alone and report the fill.
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        fill <= fill_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status <= status_next;
      found <= found_next;
      position <= sle_pkg::POS_W'(pos_next);
      count <= sle_pkg::COUNT_W'(fill_next);
    end
  end

endmodule

// ===== hw/rtl/sle_checker.sv =====
module sle_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic [sle_pkg::STATUS_W-1:0]       status,
  input logic                               found,
  input logic [sle_pkg::COUNT_W-1:0]        count
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result pending right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(count))
    else $error("stalled result changed");

  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && found |-> status == sle_pkg::ST_OK)
    else $error("match reported with a failing status");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == sle_pkg::ST_FULL |->
      count == sle_pkg::COUNT_W'(sle_pkg::DEPTH))
    else $error("full status without a full store");

  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == sle_pkg::ST_EMPTY |-> count == '0)
    else $error("empty status with stored values");

endmodule

bind sorted_list_engine sle_checker u_sle_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .status    (status),
  .found     (found),
  .count     (count)
);
